// ===== design/sgi_pkg.sv =====
// Shared widths, payload types and stage structs for the segment intersection pipeline.
`default_nettype none

package sgi_pkg;

  localparam int COORD_WIDTH = 16;
  // signed difference of two coordinates
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // product of two differences
  localparam int PROD_W      = 2 * DIFF_W;
  // difference of two products (den, snum, tnum)
  localparam int CROSS_W     = PROD_W + 1;
  // magnitude of a direction component
  localparam int MAG_W       = COORD_WIDTH;
  // tnum times a direction magnitude
  localparam int SCALED_W    = CROSS_W + MAG_W;
  // quotient bits: the rounded-down quotient never exceeds the magnitude
  localparam int QUO_W       = MAG_W;
  // start point plus signed rounded offset
  localparam int SUM_W       = COORD_WIDTH + 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
  } seg_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
  } res_t;

  // leaves the setup stages: sign-normalized tnum and den, hit decided
  typedef struct packed {
    logic                          valid;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] p0x;
    logic signed [COORD_WIDTH-1:0] p0y;
    logic                          neg_x;
    logic                          neg_y;
    logic [MAG_W-1:0]              mag_x;
    logic [MAG_W-1:0]              mag_y;
    logic [CROSS_W-1:0]            tnum;
    logic [CROSS_W-1:0]            den;
  } setup_t;

  // one slot of the divider chain, both axes share the divisor
  typedef struct packed {
    logic                          valid;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] p0x;
    logic signed [COORD_WIDTH-1:0] p0y;
    logic                          neg_x;
    logic                          neg_y;
    logic [CROSS_W-1:0]            den;
    logic [SCALED_W-1:0]           dsh;
    logic [SCALED_W-1:0]           rem_x;
    logic [SCALED_W-1:0]           rem_y;
    logic [QUO_W-1:0]              q_x;
    logic [QUO_W-1:0]              q_y;
  } div_t;

endpackage

`default_nettype wire

// ===== design/sgi_setup.sv =====
// Front stages: differences, products, cross terms, sign normalization and range test.
`default_nettype none

module sgi_setup (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           seg_valid,
  input  wire sgi_pkg::seg_t  seg,
  output sgi_pkg::setup_t     setup
);

  // stage 1: differences
  logic                                   v1;
  logic signed [sgi_pkg::COORD_WIDTH-1:0] r1_p0x, r1_p0y;
  logic signed [sgi_pkg::DIFF_W-1:0]      r1_ax, r1_ay, r1_bx, r1_by, r1_dx, r1_dy;

  // stage 2: products
  logic                                   v2;
  logic signed [sgi_pkg::COORD_WIDTH-1:0] r2_p0x, r2_p0y;
  logic                                   r2_neg_x, r2_neg_y;
  logic [sgi_pkg::MAG_W-1:0]              r2_mag_x, r2_mag_y;
  logic signed [sgi_pkg::PROD_W-1:0]      r2_axby, r2_bxay, r2_axdy, r2_aydx, r2_bxdy, r2_bydx;

  // stage 3: cross terms
  logic                                   v3;
  logic signed [sgi_pkg::COORD_WIDTH-1:0] r3_p0x, r3_p0y;
  logic                                   r3_neg_x, r3_neg_y;
  logic [sgi_pkg::MAG_W-1:0]              r3_mag_x, r3_mag_y;
  logic signed [sgi_pkg::CROSS_W-1:0]     r3_den, r3_snum, r3_tnum;

  logic [sgi_pkg::DIFF_W-1:0]             abs_ax, abs_ay;
  logic                                   den_pos, den_nz, s_ok, t_ok;

  always_comb begin
    abs_ax = r1_ax[sgi_pkg::DIFF_W-1] ? (~r1_ax + 1'b1) : r1_ax;
    abs_ay = r1_ay[sgi_pkg::DIFF_W-1] ? (~r1_ay + 1'b1) : r1_ay;
  end

  // closed range test of snum/den and tnum/den without division
  always_comb begin
    den_pos = !r3_den[sgi_pkg::CROSS_W-1];
    den_nz  = (r3_den != 0);
    if (den_pos) begin
      s_ok = !r3_snum[sgi_pkg::CROSS_W-1] && (r3_snum <= r3_den);
      t_ok = !r3_tnum[sgi_pkg::CROSS_W-1] && (r3_tnum <= r3_den);
    end else begin
      s_ok = (r3_snum[sgi_pkg::CROSS_W-1] || (r3_snum == 0)) && (r3_snum >= r3_den);
      t_ok = (r3_tnum[sgi_pkg::CROSS_W-1] || (r3_tnum == 0)) && (r3_tnum >= r3_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      setup.valid <= 1'b0;
    end else if (en) begin
      v1          <= seg_valid;
      v2          <= v1;
      v3          <= v2;
      setup.valid <= v3;
    end
    if (en) begin
      r1_p0x <= seg.a_start_x;
      r1_p0y <= seg.a_start_y;
      r1_ax  <= {seg.a_end_x[sgi_pkg::COORD_WIDTH-1], seg.a_end_x}
              - {seg.a_start_x[sgi_pkg::COORD_WIDTH-1], seg.a_start_x};
      r1_ay  <= {seg.a_end_y[sgi_pkg::COORD_WIDTH-1], seg.a_end_y}
              - {seg.a_start_y[sgi_pkg::COORD_WIDTH-1], seg.a_start_y};
      r1_bx  <= {seg.b_end_x[sgi_pkg::COORD_WIDTH-1], seg.b_end_x}
              - {seg.b_start_x[sgi_pkg::COORD_WIDTH-1], seg.b_start_x};
      r1_by  <= {seg.b_end_y[sgi_pkg::COORD_WIDTH-1], seg.b_end_y}
              - {seg.b_start_y[sgi_pkg::COORD_WIDTH-1], seg.b_start_y};
      r1_dx  <= {seg.a_start_x[sgi_pkg::COORD_WIDTH-1], seg.a_start_x}
              - {seg.b_start_x[sgi_pkg::COORD_WIDTH-1], seg.b_start_x};
      r1_dy  <= {seg.a_start_y[sgi_pkg::COORD_WIDTH-1], seg.a_start_y}
              - {seg.b_start_y[sgi_pkg::COORD_WIDTH-1], seg.b_start_y};

      r2_p0x   <= r1_p0x;
      r2_p0y   <= r1_p0y;
      r2_neg_x <= r1_ax[sgi_pkg::DIFF_W-1];
      r2_neg_y <= r1_ay[sgi_pkg::DIFF_W-1];
      r2_mag_x <= abs_ax[sgi_pkg::MAG_W-1:0];
      r2_mag_y <= abs_ay[sgi_pkg::MAG_W-1:0];
      r2_axby  <= sgi_pkg::PROD_W'(r1_ax) * sgi_pkg::PROD_W'(r1_by);
      r2_bxay  <= sgi_pkg::PROD_W'(r1_bx) * sgi_pkg::PROD_W'(r1_ay);
      r2_axdy  <= sgi_pkg::PROD_W'(r1_ax) * sgi_pkg::PROD_W'(r1_dy);
      r2_aydx  <= sgi_pkg::PROD_W'(r1_ay) * sgi_pkg::PROD_W'(r1_dx);
      r2_bxdy  <= sgi_pkg::PROD_W'(r1_bx) * sgi_pkg::PROD_W'(r1_dy);
      r2_bydx  <= sgi_pkg::PROD_W'(r1_by) * sgi_pkg::PROD_W'(r1_dx);

      r3_p0x   <= r2_p0x;
      r3_p0y   <= r2_p0y;
      r3_neg_x <= r2_neg_x;
      r3_neg_y <= r2_neg_y;
      r3_mag_x <= r2_mag_x;
      r3_mag_y <= r2_mag_y;
      r3_den   <= sgi_pkg::CROSS_W'(r2_axby) - sgi_pkg::CROSS_W'(r2_bxay);
      r3_snum  <= sgi_pkg::CROSS_W'(r2_axdy) - sgi_pkg::CROSS_W'(r2_aydx);
      r3_tnum  <= sgi_pkg::CROSS_W'(r2_bxdy) - sgi_pkg::CROSS_W'(r2_bydx);

      setup.hit   <= den_nz && s_ok && t_ok;
      setup.p0x   <= r3_p0x;
      setup.p0y   <= r3_p0y;
      setup.neg_x <= r3_neg_x;
      setup.neg_y <= r3_neg_y;
      setup.mag_x <= r3_mag_x;
      setup.mag_y <= r3_mag_y;
      setup.tnum  <= den_pos ? r3_tnum : (~r3_tnum + 1'b1);
      setup.den   <= den_pos ? r3_den : (~r3_den + 1'b1);
    end
  end

endmodule

`default_nettype wire

// ===== design/sgi_scale.sv =====
// Scale stage: tnum times each direction magnitude, loads the divider chain.
`default_nettype none

module sgi_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire sgi_pkg::setup_t setup,
  output sgi_pkg::div_t        div
);

  always_ff @(posedge clk) begin
    if (rst) begin
      div.valid <= 1'b0;
    end else if (en) begin
      div.valid <= setup.valid;
    end
    if (en) begin
      div.hit   <= setup.hit;
      div.p0x   <= setup.p0x;
      div.p0y   <= setup.p0y;
      div.neg_x <= setup.neg_x;
      div.neg_y <= setup.neg_y;
      div.den   <= setup.den;
      // divisor aligned to the top quotient bit
      div.dsh   <= sgi_pkg::SCALED_W'(setup.den) << (sgi_pkg::QUO_W - 1);
      div.rem_x <= sgi_pkg::SCALED_W'(setup.tnum) * sgi_pkg::SCALED_W'(setup.mag_x);
      div.rem_y <= sgi_pkg::SCALED_W'(setup.tnum) * sgi_pkg::SCALED_W'(setup.mag_y);
      div.q_x   <= '0;
      div.q_y   <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/sgi_div_step.sv =====
// One restoring-division step for both axes: one quotient bit per stage.
`default_nettype none

module sgi_div_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire sgi_pkg::div_t prev,
  output sgi_pkg::div_t      next
);

  logic ge_x, ge_y;

  always_comb begin
    ge_x = (prev.rem_x >= prev.dsh);
    ge_y = (prev.rem_y >= prev.dsh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
    if (en) begin
      next.hit   <= prev.hit;
      next.p0x   <= prev.p0x;
      next.p0y   <= prev.p0y;
      next.neg_x <= prev.neg_x;
      next.neg_y <= prev.neg_y;
      next.den   <= prev.den;
      next.dsh   <= prev.dsh >> 1;
      next.rem_x <= ge_x ? (prev.rem_x - prev.dsh) : prev.rem_x;
      next.rem_y <= ge_y ? (prev.rem_y - prev.dsh) : prev.rem_y;
      next.q_x   <= {prev.q_x[sgi_pkg::QUO_W-2:0], ge_x};
      next.q_y   <= {prev.q_y[sgi_pkg::QUO_W-2:0], ge_y};
    end
  end

endmodule

`default_nettype wire

// ===== design/segment_intersection_unit.sv =====
// Top level: 2D segment intersection pipeline with rounded crossing point.
//
//   channel  | valid      | stall      | payload          | dir
//   ---------+------------+------------+------------------+-----
//   segments | seg_valid  | seg_stall  | seg   (seg_t)    | in
//   results  | res_valid  | res_stall  | res   (res_t)    | out
//
// One item enters per cycle while the pipe is not stalled; the path runs through
// four setup stages, one scale stage, QUO_W (16) divider steps of one quotient bit
// each, and the rounding / output register. Throughput is set by the single shared enable.
// Reset (rst, synchronous) clears only the valid bits along the pipe.
// A stalled result freezes the whole pipe and raises seg_stall in the same
// cycle; nothing is dropped or repeated.
`default_nettype none

module segment_intersection_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          seg_valid,
  output logic               seg_stall,
  input  wire sgi_pkg::seg_t seg,
  output logic               res_valid,
  input  wire logic          res_stall,
  output sgi_pkg::res_t      res
);

  logic            en;
  sgi_pkg::setup_t setup;
  sgi_pkg::div_t   stage_d [0:sgi_pkg::QUO_W];

  // pipe advances unless the output register holds an item nobody takes
  assign en        = !(res_valid && res_stall);
  assign seg_stall = !en;

  sgi_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .seg_valid (seg_valid),
    .seg       (seg),
    .setup     (setup)
  );

  sgi_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .setup (setup),
    .div   (stage_d[0])
  );

  for (genvar k = 0; k < sgi_pkg::QUO_W; k++) begin : g_div
    sgi_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (stage_d[k]),
      .next (stage_d[k+1])
    );
  end

  // rounding: bump the quotient when twice the remainder reaches den
  sgi_pkg::div_t                      fin;
  logic                               up_x, up_y;
  logic [sgi_pkg::QUO_W:0]            qr_x, qr_y;
  logic signed [sgi_pkg::SUM_W-1:0]   sum_x, sum_y;
  logic signed [sgi_pkg::SUM_W-1:0]   off_x, off_y;

  always_comb begin
    fin   = stage_d[sgi_pkg::QUO_W];
    up_x  = ({fin.rem_x, 1'b0} >= (sgi_pkg::SCALED_W + 1)'(fin.den));
    up_y  = ({fin.rem_y, 1'b0} >= (sgi_pkg::SCALED_W + 1)'(fin.den));
    qr_x  = (sgi_pkg::QUO_W + 1)'(fin.q_x) + (sgi_pkg::QUO_W + 1)'(up_x);
    qr_y  = (sgi_pkg::QUO_W + 1)'(fin.q_y) + (sgi_pkg::QUO_W + 1)'(up_y);
    off_x = $signed(sgi_pkg::SUM_W'(qr_x));
    off_y = $signed(sgi_pkg::SUM_W'(qr_y));
    sum_x = fin.neg_x ? (sgi_pkg::SUM_W'(fin.p0x) - off_x)
                      : (sgi_pkg::SUM_W'(fin.p0x) + off_x);
    sum_y = fin.neg_y ? (sgi_pkg::SUM_W'(fin.p0y) - off_y)
                      : (sgi_pkg::SUM_W'(fin.p0y) + off_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin.valid;
    end
    if (en) begin
      res.hit     <= fin.hit;
      // point lies on segment A, so it always fits the coordinate field
      res.cross_x <= fin.hit ? sum_x[sgi_pkg::COORD_WIDTH-1:0] : '0;
      res.cross_y <= fin.hit ? sum_y[sgi_pkg::COORD_WIDTH-1:0] : '0;
    end
  end

  // no hit means a zero point
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |-> res.cross_x == 0 && res.cross_y == 0)
    else $error("no-hit result carries a nonzero point");

  // input side only stalls when the output holds an untaken item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !seg_stall)
    else $error("input stalled with empty output");

  // a stalled output freezes the divider tail
  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(stage_d[sgi_pkg::QUO_W]))
    else $error("divider tail moved during stall");

  // a hit enters the divider only with a positive divisor
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    stage_d[0].valid && stage_d[0].hit |->
      stage_d[0].den != 0 && !stage_d[0].den[sgi_pkg::CROSS_W-1])
    else $error("hit with non-positive denominator");

endmodule

`default_nettype wire

// ===== sim/segment_intersection_unit_tb.sv =====
// Self-checking testbench for segment_intersection_unit: predicted crossings vs DUT results.
`timescale 1ns / 1ps

module segment_intersection_unit_tb;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input has a known value at time 0.
  // ---------------------------------------------------------------------
  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          seg_valid = 1'b0;
  logic          res_stall = 1'b0;
  sgi_pkg::seg_t seg       = '0;
  logic          seg_stall;
  logic          res_valid;
  sgi_pkg::res_t res;

  always #10 clk = ~clk;

  segment_intersection_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // ---------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------
  sgi_pkg::seg_t pending_segs[$];       // items not yet presented to the DUT
  sgi_pkg::res_t expected_crossings[$]; // predictions for accepted items, oldest first
  int   total_items = 1;
  int   issued      = 0;
  int   errors      = 0;
  logic seg_taken   = 1'b0;   // item on the bus was accepted at the last edge
  int   traffic_phase;
  int   send_idle_pct;
  int   recv_stall_pct;

  // Three flow-control phases by progress through the item list:
  // busy sender / sparse receiver, then sparse sender / busy receiver,
  // then full rate on both sides.
  always_comb begin
    traffic_phase = (issued * 3) / total_items;
    case (traffic_phase)
      0: begin
        send_idle_pct  = 10;
        recv_stall_pct = 78;
      end
      1: begin
        send_idle_pct  = 78;
        recv_stall_pct = 10;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Crossing predictor. All intermediates in 64 bits: differences are 17
  // bits, cross products 35, tnum times a direction magnitude 51, so
  // nothing wraps.
  // ---------------------------------------------------------------------

  // start + round(tnum * |dir| / den) in the direction of dir,
  // ties away from zero; 0 <= tnum <= den, den > 0
  function automatic longint walk_along(longint start, longint dir, longint tnum,
                                        longint den);
    longint mag, scaled, q;
    mag    = (dir < 0) ? -dir : dir;
    scaled = tnum * mag;
    q      = scaled / den;
    if (2 * (scaled - q * den) >= den) q++;
    return (dir < 0) ? start - q : start + q;
  endfunction

  function automatic sgi_pkg::res_t predict_crossing(sgi_pkg::seg_t s);
    longint p0x, p0y, ax, ay, bx, by, dx, dy, den, snum, tnum;
    sgi_pkg::res_t r;
    p0x  = $signed(s.a_start_x);
    p0y  = $signed(s.a_start_y);
    ax   = $signed(s.a_end_x) - p0x;
    ay   = $signed(s.a_end_y) - p0y;
    bx   = $signed(s.b_end_x) - $signed(s.b_start_x);
    by   = $signed(s.b_end_y) - $signed(s.b_start_y);
    dx   = p0x - $signed(s.b_start_x);
    dy   = p0y - $signed(s.b_start_y);
    den  = ax * by - bx * ay;
    snum = ax * dy - ay * dx;
    tnum = bx * dy - by * dx;
    r    = '0;
    // normalize so den is positive; the [0,1] tests are then plain compares
    if (den < 0) begin
      den  = -den;
      snum = -snum;
      tnum = -tnum;
    end
    // zero den (parallel, collinear, degenerate) never hits
    if (den != 0 && snum >= 0 && tnum >= 0 && snum <= den && tnum <= den) begin
      r.hit     = 1'b1;
      r.cross_x = sgi_pkg::COORD_WIDTH'(walk_along(p0x, ax, tnum, den));
      r.cross_y = sgi_pkg::COORD_WIDTH'(walk_along(p0y, ay, tnum, den));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic sgi_pkg::seg_t pack_segments(int asx, int asy, int aex, int aey,
                                                  int bsx, int bsy, int bex, int bey);
    sgi_pkg::seg_t s;
    s.a_start_x = sgi_pkg::COORD_WIDTH'(asx);
    s.a_start_y = sgi_pkg::COORD_WIDTH'(asy);
    s.a_end_x   = sgi_pkg::COORD_WIDTH'(aex);
    s.a_end_y   = sgi_pkg::COORD_WIDTH'(aey);
    s.b_start_x = sgi_pkg::COORD_WIDTH'(bsx);
    s.b_start_y = sgi_pkg::COORD_WIDTH'(bsy);
    s.b_end_x   = sgi_pkg::COORD_WIDTH'(bex);
    s.b_end_y   = sgi_pkg::COORD_WIDTH'(bey);
    return s;
  endfunction

  // append one item to the end of the pending list
  function automatic void queue_seg(sgi_pkg::seg_t s);
    pending_segs.insert(pending_segs.size(), s);
  endfunction

  // uniform in [-lim, lim]
  function automatic int span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: new item at the falling edge once the current one is taken.
  // Valid is decided without looking at seg_stall.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (!seg_valid || seg_taken) begin
      if (pending_segs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        seg       <= pending_segs.pop_front();
        seg_valid <= 1'b1;
        issued    <= issued + 1;
      end else begin
        seg_valid <= 1'b0;
      end
    end
    res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: checks results against the oldest prediction, then records
  // the prediction for any item accepted at this edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    sgi_pkg::res_t want;
    seg_taken <= seg_valid && !seg_stall;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected result: expected none, got hit=%0b x=%0d y=%0d",
                   $time, res.hit, res.cross_x, res.cross_y);
          errors++;
        end else begin
          want = expected_crossings.pop_front();
          if (res.hit !== want.hit || res.cross_x !== want.cross_x ||
              res.cross_y !== want.cross_y) begin
            $display("%0t: mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     $time, want.hit, want.cross_x, want.cross_y,
                     res.hit, res.cross_x, res.cross_y);
            errors++;
          end
        end
      end
      if (seg_valid && !seg_stall)
        expected_crossings.insert(expected_crossings.size(), predict_crossing(seg));
    end
  end

  // ---------------------------------------------------------------------
  // Item list, reset, and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int sx, sy, ex, ey, px, py, ux, uy, m1, m2, k, ax, ay, c, shift, off, pick;

    // directed: extremes and corner cases
    queue_seg(pack_segments(0, 0, 160, 160, 0, 160, 160, 0));
    // same crossing with B reversed, so den flips sign
    queue_seg(pack_segments(0, 0, 160, 160, 160, 0, 0, 160));
    // full-range diagonals: 17-bit differences
    queue_seg(pack_segments(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768));
    queue_seg(pack_segments(32767, 0, -32768, 0, 0, -32768, 0, 32767));
    // all minimum, all maximum, all zero: degenerate
    queue_seg(pack_segments(-32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768));
    queue_seg(pack_segments(32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767));
    queue_seg(pack_segments(0, 0, 0, 0, 0, 0, 0, 0));
    // parallel, collinear overlap
    queue_seg(pack_segments(0, 0, 100, 0, 0, 10, 100, 10));
    queue_seg(pack_segments(0, 0, 100, 0, 50, 0, 150, 0));
    // A is a point lying on B; B is a point lying on A
    queue_seg(pack_segments(5, 5, 5, 5, 0, 0, 10, 10));
    queue_seg(pack_segments(0, 0, 10, 10, 5, 5, 5, 5));
    // touching at the start and the end of A
    queue_seg(pack_segments(0, 0, 100, 0, 0, -50, 0, 50));
    queue_seg(pack_segments(0, 0, 100, 0, 100, -50, 100, 50));
    // B starts on A, B ends on A
    queue_seg(pack_segments(0, -50, 0, 50, 0, 0, 100, 0));
    queue_seg(pack_segments(0, -50, 0, 50, -100, 0, 0, 0));
    // just past the end of A, and on the line before its start
    queue_seg(pack_segments(0, 0, 100, 0, 101, -50, 101, 50));
    queue_seg(pack_segments(0, 0, 100, 0, -10, -50, -10, 50));
    // B just short of reaching A
    queue_seg(pack_segments(0, 0, 100, 0, 50, 1, 50, 50));
    // rounding ties at exactly one half, both direction signs and both axes
    queue_seg(pack_segments(0, 0, 1, 0, 0, -1, 1, 1));
    queue_seg(pack_segments(0, 0, -1, 0, 0, -1, -1, 1));
    queue_seg(pack_segments(0, 0, 0, -1, -1, 0, 1, -1));
    queue_seg(pack_segments(0, 0, 0, 1, -1, 0, 1, 1));

    // random part
    repeat (1130) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // full range, every bit of every field
        queue_seg(pack_segments($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom));
      end else if (pick < 25) begin
        // small coordinates: dense mix of hits, misses and near-parallels
        queue_seg(pack_segments(span(64), span(64), span(64), span(64),
                                span(64), span(64), span(64), span(64)));
      end else if (pick < 37) begin
        // B parallel to A (c == 0 makes B a point), sometimes collinear
        sx = span(4000); sy = span(4000);
        ax = span(2000); ay = span(2000);
        if ($urandom_range(9) == 0) begin
          ax = 0;
          ay = 0;
        end
        c     = span(2);
        shift = span(2);
        off   = $urandom_range(1) ? 0 : span(100);
        queue_seg(pack_segments(sx, sy, sx + ax, sy + ay,
                                sx + shift * ax, sy + shift * ay + off,
                                sx + (shift + c) * ax,
                                sy + (shift + c) * ay + off));
      end else begin
        // B built through a point on A: mostly hits, endpoints included
        sx = span(8000); sy = span(8000);
        ex = span(8000); ey = span(8000);
        k  = $urandom_range(16);
        px = sx + (ex - sx) * k / 16;
        py = sy + (ey - sy) * k / 16;
        ux = span(255); uy = span(255);
        m1 = $urandom_range(15);
        m2 = $urandom_range(15);
        queue_seg(pack_segments(sx, sy, ex, ey,
                                px - ux * m1, py - uy * m1,
                                px + ux * m2, py + uy * m2));
      end
    end
    total_items = pending_segs.size();

    // synchronous reset, released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all items taken, then all results back, then drain past the latency
    while (pending_segs.size() != 0 || seg_valid) @(posedge clk);
    while (expected_crossings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("segment_intersection_unit_tb: PASS");
    end else begin
      $display("segment_intersection_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("segment_intersection_unit_tb: FAIL");
    $finish;
  end

endmodule
